/* sv/pirdp_pkg.sv */
// Shared types, constants and the operation table of the patch depth picker.
package pirdp_pkg;

  localparam int W = 192;
  localparam int YW = 96;
  localparam int WORDS_PER_PATCH = 9;
  localparam int GLYPH_WORD = 9;
  localparam int DIST_LIMIT = 10000;
  localparam logic [7:0] SPACE_GLYPH = 8'd32;
  localparam logic [4:0] PC_SOLVE_END = 5'd17;
  localparam logic [4:0] PC_LAST = 5'd29;

  typedef enum logic [1:0] {
    REG_SURFACES = 2'd0,
    REG_OFFSET_ROW = 2'd1,
    REG_OFFSET_COL = 2'd2,
    REG_FOCAL_DEPTH = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_DIV = 2'd1,
    CMD_LT = 2'd2
  } unit_cmd_t;

  typedef struct packed {
    logic start;
    unit_cmd_t cmd;
    logic neg;
    logic clr;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic flag;
  } unit_rsp_t;

  typedef enum logic [4:0] {
    SRC_EZ, SRC_EZ2, SRC_RD, SRC_CD,
    SRC_K0, SRC_K1, SRC_K2, SRC_K3, SRC_K4, SRC_K5, SRC_K6, SRC_K7, SRC_K8,
    SRC_A, SRC_B, SRC_C, SRC_D, SRC_E, SRC_G,
    SRC_S, SRC_T, SRC_ONE, SRC_PX, SRC_PY, SRC_PZ
  } src_t;

  typedef enum logic [3:0] {
    DST_A, DST_B, DST_C, DST_D, DST_E, DST_G,
    DST_DET, DST_N1, DST_N2, DST_PX, DST_PY, DST_PZ, DST_LEN
  } dst_t;

  typedef struct packed {
    src_t xs;
    src_t ys;
    dst_t dst;
    logic neg;
    logic clr;
  } op_t;

  function automatic op_t op_entry(input logic [4:0] pc);
    op_t o;
    case (pc)
      5'd0: o = '{SRC_K0, SRC_EZ, DST_A, 1'b0, 1'b1};
      5'd1: o = '{SRC_RD, SRC_K6, DST_A, 1'b1, 1'b0};
      5'd2: o = '{SRC_K1, SRC_EZ, DST_B, 1'b0, 1'b1};
      5'd3: o = '{SRC_RD, SRC_K7, DST_B, 1'b1, 1'b0};
      5'd4: o = '{SRC_RD, SRC_K8, DST_C, 1'b0, 1'b1};
      5'd5: o = '{SRC_K2, SRC_EZ, DST_C, 1'b1, 1'b0};
      5'd6: o = '{SRC_K3, SRC_EZ2, DST_D, 1'b0, 1'b1};
      5'd7: o = '{SRC_CD, SRC_K6, DST_D, 1'b1, 1'b0};
      5'd8: o = '{SRC_K4, SRC_EZ2, DST_E, 1'b0, 1'b1};
      5'd9: o = '{SRC_CD, SRC_K7, DST_E, 1'b1, 1'b0};
      5'd10: o = '{SRC_CD, SRC_K8, DST_G, 1'b0, 1'b1};
      5'd11: o = '{SRC_K5, SRC_EZ2, DST_G, 1'b1, 1'b0};
      5'd12: o = '{SRC_A, SRC_E, DST_DET, 1'b0, 1'b1};
      5'd13: o = '{SRC_B, SRC_D, DST_DET, 1'b1, 1'b0};
      5'd14: o = '{SRC_C, SRC_E, DST_N1, 1'b0, 1'b1};
      5'd15: o = '{SRC_B, SRC_G, DST_N1, 1'b1, 1'b0};
      5'd16: o = '{SRC_A, SRC_G, DST_N2, 1'b0, 1'b1};
      5'd17: o = '{SRC_C, SRC_D, DST_N2, 1'b1, 1'b0};
      5'd18: o = '{SRC_K0, SRC_S, DST_PX, 1'b0, 1'b1};
      5'd19: o = '{SRC_K1, SRC_T, DST_PX, 1'b0, 1'b0};
      5'd20: o = '{SRC_K2, SRC_ONE, DST_PX, 1'b0, 1'b0};
      5'd21: o = '{SRC_K3, SRC_S, DST_PY, 1'b0, 1'b1};
      5'd22: o = '{SRC_K4, SRC_T, DST_PY, 1'b0, 1'b0};
      5'd23: o = '{SRC_K5, SRC_ONE, DST_PY, 1'b0, 1'b0};
      5'd24: o = '{SRC_K6, SRC_S, DST_PZ, 1'b0, 1'b1};
      5'd25: o = '{SRC_K7, SRC_T, DST_PZ, 1'b0, 1'b0};
      5'd26: o = '{SRC_K8, SRC_ONE, DST_PZ, 1'b0, 1'b0};
      5'd27: o = '{SRC_PX, SRC_PX, DST_LEN, 1'b0, 1'b1};
      5'd28: o = '{SRC_PY, SRC_PY, DST_LEN, 1'b0, 1'b0};
      5'd29: o = '{SRC_PZ, SRC_PZ, DST_LEN, 1'b0, 1'b0};
      default: o = '{SRC_K0, SRC_EZ, DST_A, 1'b0, 1'b1};
    endcase
    return o;
  endfunction

endpackage

/* sv/patch_inverse_raster_depth_pick_unit.sv */
// Top level of the patch depth picker: table storage, sequencer and stream ports.
//
// Input items arrive on the s_ stream. s_tuser set to 0 makes a write transaction
// that stores one coefficient word or glyph; it completes in the accept cycle and
// gives no result. s_tuser set to 1 shades a pixel: every patch in use is loaded
// from the coefficient RAM and then put through thirty multiply-accumulate
// steps, two divisions and one compare on the shared unit; a patch whose
// division fails skips its remaining steps and the compare. The multiplier is
// serial, so a multiplication occupies the sequencer for longer the more
// significant bits its second operand has. With Q16.16 data the serial
// multiplier sets the cost of a patch. After the last patch the glyph lookup
// and the output load finish the pixel.
// s_tready is high only while the sequencer is idle.
// One result transaction per pixel leaves on the m_ stream from an output
// register; a finished pixel waits there while the receiver stalls, and the
// next pixel is accepted meanwhile; once done it waits in the sequencer.
// Reset clears the configuration registers to their defaults and empties the
// output register. The patch tables hold no reset value and have to be written
// before use; there is no clearing pass.
module patch_inverse_raster_depth_pick_unit
  import pirdp_pkg::*;
#(
  parameter int MAX_PATCHES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // patch_slot, word_slot, word_value, pixel_row, pixel_col
  input  logic [71:0] s_tdata,
  // mode
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_row, out_col, glyph, winner_slot, zero fill
  output logic [47:0] m_tdata,
  // covered
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CDEPTH = MAX_PATCHES * WORDS_PER_PATCH;
  localparam int AW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int GW = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
  localparam int PW = $clog2(MAX_PATCHES + 1);
  localparam int RDW = ((16 + FRAC_BITS) > 32 ? 16 + FRAC_BITS : 32) + 2;
  localparam logic [W-1:0] ONE_W = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] LIMIT_SQ = W'(DIST_LIMIT * DIST_LIMIT) << (4 * FRAC_BITS);
  localparam logic [AW-1:0] STRIDE = AW'(WORDS_PER_PATCH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_OP, ST_OPW, ST_DIV, ST_DIVW, ST_CMP, ST_CMPW,
    ST_NEXT, ST_GLY, ST_GLYW, ST_EMIT
  } state_t;

  state_t state;

  logic [4:0] surfaces_in_use;
  logic signed [31:0] offset_row;
  logic signed [31:0] offset_col;
  logic signed [31:0] focal_depth;

  logic [3:0] in_patch_slot;
  logic [3:0] in_word_slot;
  logic [31:0] in_word_value;
  logic signed [15:0] in_row;
  logic signed [15:0] in_col;

  logic signed [15:0] row;
  logic signed [15:0] col;
  logic signed [31:0] ez;
  logic signed [32:0] ez2;
  logic signed [RDW-1:0] rd;
  logic signed [RDW-1:0] cd;
  logic signed [31:0] k [9];
  logic [W-1:0] a, b, c, d, e, g;
  logic [W-1:0] det, n1, n2;
  logic [W-1:0] px, py, pz, len, best;
  logic [FRAC_BITS:0] s, t;
  logic [4:0] pc;
  logic div_sel;
  logic [3:0] ld;
  logic [PW-1:0] p;
  logic [PW-1:0] count;
  logic [AW-1:0] rbase;
  logic [GW-1:0] best_slot;
  logic found;
  logic [7:0] glyph_r;

  logic [15:0] out_row;
  logic [15:0] out_col;
  logic [7:0] out_glyph;
  logic [3:0] out_slot;
  logic out_cov;

  op_t op;
  unit_req_t req;
  unit_rsp_t rsp;
  logic [W-1:0] opa, opb;
  logic [W-1:0] res;
  logic [FRAC_BITS:0] quot;

  logic in_acc;
  logic [11:0] waddr_full;
  logic coef_we, glyph_we;
  logic [AW-1:0] coef_waddr, coef_raddr;
  logic [31:0] coef_rdata;
  logic [7:0] glyph_rdata;
  logic [PW-1:0] count_in;

  assign in_patch_slot = s_tdata[3:0];
  assign in_word_slot = s_tdata[7:4];
  assign in_word_value = s_tdata[39:8];
  assign in_row = s_tdata[55:40];
  assign in_col = s_tdata[71:56];

  assign s_tready = (state == ST_IDLE);
  assign in_acc = s_tvalid && s_tready;

  assign waddr_full = ({8'd0, in_patch_slot} << 3) + {8'd0, in_patch_slot} +
                      {8'd0, in_word_slot};
  assign coef_waddr = AW'(waddr_full);
  assign coef_we = in_acc && !s_tuser && (32'(in_patch_slot) < MAX_PATCHES) &&
                   (32'(in_word_slot) < WORDS_PER_PATCH);
  assign glyph_we = in_acc && !s_tuser && (32'(in_patch_slot) < MAX_PATCHES) &&
                    (32'(in_word_slot) == GLYPH_WORD);
  assign coef_raddr = rbase + AW'(ld);
  assign count_in = (32'(surfaces_in_use) > MAX_PATCHES) ? PW'(MAX_PATCHES)
                                                         : PW'(surfaces_in_use);

  pirdp_ram #(.WIDTH(32), .DEPTH(CDEPTH), .ADDR_W(AW)) u_coef_ram (
    .clk  (clk),
    .we   (coef_we),
    .waddr(coef_waddr),
    .wdata(in_word_value),
    .re   (state == ST_LOAD && ld < 4'(WORDS_PER_PATCH)),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  pirdp_ram #(.WIDTH(8), .DEPTH(MAX_PATCHES), .ADDR_W(GW)) u_glyph_ram (
    .clk  (clk),
    .we   (glyph_we),
    .waddr(GW'(in_patch_slot)),
    .wdata(in_word_value[7:0]),
    .re   (state == ST_GLY),
    .raddr(best_slot),
    .rdata(glyph_rdata)
  );

  function automatic logic [W-1:0] pick(input src_t sel);
    logic [W-1:0] v;
    case (sel)
      SRC_EZ: v = W'(ez);
      SRC_EZ2: v = W'(ez2);
      SRC_RD: v = W'(rd);
      SRC_CD: v = W'(cd);
      SRC_K0: v = W'(k[0]);
      SRC_K1: v = W'(k[1]);
      SRC_K2: v = W'(k[2]);
      SRC_K3: v = W'(k[3]);
      SRC_K4: v = W'(k[4]);
      SRC_K5: v = W'(k[5]);
      SRC_K6: v = W'(k[6]);
      SRC_K7: v = W'(k[7]);
      SRC_K8: v = W'(k[8]);
      SRC_A: v = a;
      SRC_B: v = b;
      SRC_C: v = c;
      SRC_D: v = d;
      SRC_E: v = e;
      SRC_G: v = g;
      SRC_S: v = W'(s);
      SRC_T: v = W'(t);
      SRC_ONE: v = ONE_W;
      SRC_PX: v = px;
      SRC_PY: v = py;
      SRC_PZ: v = pz;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign op = op_entry(pc);

  always_comb begin
    req = '{start: 1'b0, cmd: CMD_MUL, neg: op.neg, clr: op.clr};
    opa = pick(op.xs);
    opb = pick(op.ys);
    case (state)
      ST_OP: begin
        req.start = 1'b1;
      end
      ST_DIV, ST_DIVW: begin
        req.cmd = CMD_DIV;
        req.start = (state == ST_DIV);
        opa = div_sel ? n2 : n1;
        opb = det;
      end
      ST_CMP, ST_CMPW: begin
        req.cmd = CMD_LT;
        req.start = (state == ST_CMP);
        opa = len;
        opb = best;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  pirdp_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .opa (opa),
    .opb (opb),
    .rsp (rsp),
    .res (res),
    .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      surfaces_in_use <= '0;
      offset_row <= '0;
      offset_col <= '0;
      focal_depth <= 32'sd65536;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SURFACES: surfaces_in_use <= cfg_data[4:0];
          REG_OFFSET_ROW: offset_row <= cfg_data;
          REG_OFFSET_COL: offset_col <= cfg_data;
          REG_FOCAL_DEPTH: focal_depth <= cfg_data;
          default: surfaces_in_use <= surfaces_in_use;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && s_tuser) begin
            row <= in_row;
            col <= in_col;
            ez <= focal_depth;
            ez2 <= 33'(focal_depth) <<< 1;
            rd <= (RDW'(in_row) <<< FRAC_BITS) - RDW'(offset_row);
            cd <= (RDW'(in_col) <<< FRAC_BITS) - RDW'(offset_col);
            count <= count_in;
            p <= '0;
            rbase <= '0;
            ld <= '0;
            best <= LIMIT_SQ;
            best_slot <= '0;
            found <= 1'b0;
            state <= (count_in == '0) ? ST_EMIT : ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (ld != 4'd0) begin
            k[4'(ld - 4'd1)] <= coef_rdata;
          end
          if (ld == 4'(WORDS_PER_PATCH)) begin
            pc <= '0;
            state <= ST_OP;
          end else begin
            ld <= ld + 4'd1;
          end
        end
        ST_OP: begin
          state <= ST_OPW;
        end
        ST_OPW: begin
          if (rsp.done) begin
            case (op.dst)
              DST_A: a <= res;
              DST_B: b <= res;
              DST_C: c <= res;
              DST_D: d <= res;
              DST_E: e <= res;
              DST_G: g <= res;
              DST_DET: det <= res;
              DST_N1: n1 <= res;
              DST_N2: n2 <= res;
              DST_PX: px <= res;
              DST_PY: py <= res;
              DST_PZ: pz <= res;
              DST_LEN: len <= res;
              default: len <= res;
            endcase
            if (pc == PC_SOLVE_END) begin
              pc <= pc + 5'd1;
              div_sel <= 1'b0;
              state <= ST_DIV;
            end else if (pc == PC_LAST) begin
              state <= ST_CMP;
            end else begin
              pc <= pc + 5'd1;
              state <= ST_OP;
            end
          end
        end
        ST_DIV: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (rsp.done) begin
            if (rsp.flag) begin
              state <= ST_NEXT;
            end else if (!div_sel) begin
              s <= quot;
              div_sel <= 1'b1;
              state <= ST_DIV;
            end else begin
              t <= quot;
              state <= ST_OP;
            end
          end
        end
        ST_CMP: begin
          state <= ST_CMPW;
        end
        ST_CMPW: begin
          if (rsp.done) begin
            if (rsp.flag) begin
              best <= len;
              best_slot <= GW'(p);
              found <= 1'b1;
            end
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          p <= p + PW'(1);
          rbase <= rbase + STRIDE;
          ld <= '0;
          state <= (p + PW'(1) == count) ? ST_GLY : ST_LOAD;
        end
        ST_GLY: begin
          state <= ST_GLYW;
        end
        ST_GLYW: begin
          glyph_r <= glyph_rdata;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            out_row <= row;
            out_col <= col;
            out_cov <= found;
            out_glyph <= found ? glyph_r : SPACE_GLYPH;
            out_slot <= found ? 4'(best_slot) : 4'd0;
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {4'd0, out_slot, out_glyph, out_col, out_row};
  assign m_tuser = out_cov;

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[39:32] == SPACE_GLYPH && m_tdata[43:40] == 4'd0))
    else $error("Uncovered result carries a glyph or a slot.");

  assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == ST_OPW || state == ST_DIVW || state == ST_CMPW))
    else $error("Shared unit finished while the sequencer was not waiting.");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("Pixel transaction did not take the sequencer out of idle.");

endmodule

/* sv/pirdp_ram.sv */
// Generic single-port-write, registered-read RAM.
module pirdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/pirdp_unit.sv */
// Shared wide adder unit: serial multiply-accumulate, restoring divide and compare.
module pirdp_unit
  import pirdp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  unit_req_t        req,
  input  logic [W-1:0]     opa,
  input  logic [W-1:0]     opb,
  output unit_rsp_t        rsp,
  output logic [W-1:0]     res,
  output logic [FRAC_BITS:0] quot
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    U_IDLE, U_MSET, U_MRUN, U_DABSD, U_DABSN, U_DFIRST, U_DSTEP, U_CMP
  } ustate_t;

  ustate_t state;
  logic [W-1:0] acc;
  logic [W-1:0] x;
  logic [YW-1:0] y;
  logic [FRAC_BITS:0] q;
  logic [CW-1:0] cnt;
  logic negx;
  logic done;
  logic flag;

  logic [W-1:0] add_a;
  logic [W-1:0] add_b;
  logic add_sub;
  logic [W-1:0] sum;
  logic [YW-1:0] yb;
  logic ysign;
  logic div_fail;

  assign yb = opb[YW-1:0];
  assign ysign = yb[YW-1];
  assign div_fail = (opb == '0) || ((opa != '0) && (opa[W-1] != opb[W-1]));

  always_comb begin
    add_a = '0;
    add_b = '0;
    add_sub = 1'b0;
    case (state)
      U_MSET: begin
        add_b = opa;
        add_sub = negx;
      end
      U_MRUN: begin
        add_a = acc;
        add_b = x;
      end
      U_DABSD: begin
        add_b = opb;
        add_sub = opb[W-1];
      end
      U_DABSN: begin
        add_b = opa;
        add_sub = opa[W-1];
      end
      U_DFIRST: begin
        add_a = acc;
        add_b = x;
        add_sub = 1'b1;
      end
      U_DSTEP: begin
        add_a = acc << 1;
        add_b = x;
        add_sub = 1'b1;
      end
      U_CMP: begin
        add_a = opa;
        add_b = opb;
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign sum = add_a + (add_sub ? ~add_b : add_b) + W'(add_sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done <= 1'b0;
      flag <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.start) begin
            case (req.cmd)
              CMD_MUL: begin
                y <= ysign ? (~yb + YW'(1)) : yb;
                negx <= req.neg ^ ysign;
                if (req.clr) begin
                  acc <= '0;
                end
                state <= U_MSET;
              end
              CMD_DIV: begin
                if (div_fail) begin
                  done <= 1'b1;
                  flag <= 1'b1;
                end else begin
                  state <= U_DABSD;
                end
              end
              CMD_LT: begin
                state <= U_CMP;
              end
              default: begin
                state <= U_IDLE;
              end
            endcase
          end
        end
        U_MSET: begin
          x <= sum;
          state <= U_MRUN;
        end
        U_MRUN: begin
          if (y == '0) begin
            done <= 1'b1;
            flag <= 1'b0;
            state <= U_IDLE;
          end else begin
            if (y[0]) begin
              acc <= sum;
            end
            x <= x << 1;
            y <= y >> 1;
          end
        end
        U_DABSD: begin
          x <= sum;
          state <= U_DABSN;
        end
        U_DABSN: begin
          acc <= sum;
          state <= U_DFIRST;
        end
        U_DFIRST: begin
          cnt <= '0;
          if (sum[W-1]) begin
            q <= '0;
            state <= U_DSTEP;
          end else if (sum == '0) begin
            q <= (FRAC_BITS + 1)'(1);
            acc <= '0;
            state <= U_DSTEP;
          end else begin
            done <= 1'b1;
            flag <= 1'b1;
            state <= U_IDLE;
          end
        end
        U_DSTEP: begin
          if (!sum[W-1]) begin
            acc <= sum;
            q <= {q[FRAC_BITS-1:0], 1'b1};
          end else begin
            acc <= acc << 1;
            q <= {q[FRAC_BITS-1:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(FRAC_BITS - 1)) begin
            done <= 1'b1;
            flag <= 1'b0;
            state <= U_IDLE;
          end
        end
        U_CMP: begin
          done <= 1'b1;
          flag <= sum[W-1];
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  assign rsp = '{done: done, flag: flag};
  assign res = acc;
  assign quot = q;

endmodule
